### src/drse_pkg.sv
// drse_pkg: shared types and constants of the delta plus run-length encoder.
// Depends on nothing; used by the top level, its port checker and the testbench.
package drse_pkg;

    // One byte of the compressed stream
    typedef logic [7:0] byte_t;

    // Number of bytes that one sample can cause, and the matching count width
    localparam int BURST_MAX = 5;
    localparam int BURST_CW  = $clog2(BURST_MAX + 1);

    typedef logic [BURST_CW-1:0] burst_cnt_t;
    typedef byte_t burst_bytes_t [BURST_MAX];

    // Stream tags and run limit
    localparam byte_t TAG_RUN   = 8'h00;
    localparam byte_t TAG_DELTA = 8'h01;
    localparam byte_t RUN_LIMIT = 8'hFF;

endpackage

### src/delta_rle_sample_encoder_unit.sv
// delta_rle_sample_encoder_unit: delta plus run-length encoder for 16-bit samples.
// Depends on drse_pkg (byte and burst types, stream tags, run limit).
//
// Usage:
//   Input channel (in_valid / in_stall) takes one sample word per accepted
//   cycle, channel after channel, with first_of_channel / last_of_channel
//   marks. Output channel (out_valid / out_stall) gives one byte word per
//   cycle while out_stall is low; burst_end marks the last byte caused by one sample.
//   A sample is encoded in the cycle it is accepted: the previous sample and
//   run count update at once, and its 0 to 5 bytes go to a holding stage.
//   The holding stage moves into the output burst stage as soon as that one
//   is empty or hands over its last byte; a sample's first byte shows once
//   its bytes have moved from the holding stage into the output burst stage.
//   The output burst stage drives one byte a cycle while out_stall is low,
//   and the next sample can be taken while it still drives the last one's bytes.
//   in_stall is high exactly while the holding stage is full, so the input
//   side never waits on a combinational path from out_stall.
//   Reset clears the previous sample and run count to zero and empties both
//   stages. While the receiver stalls, the current byte holds and the input
//   takes at most one more sample that causes bytes.
module delta_rle_sample_encoder_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [15:0]         sample_value,
    input  logic                first_of_channel,
    input  logic                last_of_channel,
    output logic                out_valid,
    input  logic                out_stall,
    output drse_pkg::byte_t     out_byte,
    output logic                burst_end
);
    import drse_pkg::*;

    // Encoder state
    logic [15:0]  prev_sample_reg, prev_sample_next;
    byte_t        run_len_reg, run_len_next;

    // Holding stage
    logic         a_valid_reg, a_valid_next;
    burst_bytes_t a_bytes_reg, a_bytes_next;
    burst_cnt_t   a_cnt_reg, a_cnt_next;

    // Output burst stage
    logic         b_valid_reg, b_valid_next;
    burst_bytes_t b_bytes_reg, b_bytes_next;
    burst_cnt_t   b_cnt_reg, b_cnt_next;
    burst_cnt_t   b_idx_reg, b_idx_next;

    // Encoder results for the offered sample
    logic         in_accept;
    logic         pair_en;
    byte_t        pair_cnt;
    burst_cnt_t   main_len;
    byte_t        m0, m1, m2;
    burst_bytes_t enc_bytes;
    burst_cnt_t   enc_cnt;
    logic [15:0]  delta;
    byte_t        run_inc;

    // Handshake
    logic         b_take, b_done, b_load;

    assign in_stall  = a_valid_reg;
    assign in_accept = in_valid && !a_valid_reg;

    assign out_valid = b_valid_reg;
    assign out_byte  = b_bytes_reg[b_idx_reg];
    assign burst_end = (b_idx_reg == b_cnt_reg - burst_cnt_t'(1));

    assign b_take = b_valid_reg && !out_stall;
    assign b_done = b_take && burst_end;
    assign b_load = a_valid_reg && (!b_valid_reg || b_done);

    // Encode one sample: an optional run pair, then absolute or delta bytes (none for a repeat)
    always_comb
    begin
        delta    = sample_value - prev_sample_reg;
        run_inc  = run_len_reg + 8'd1;
        pair_en  = 1'b0;
        pair_cnt = run_len_reg;
        main_len = '0;
        m0       = sample_value[15:8];
        m1       = sample_value[7:0];
        m2       = '0;
        run_len_next = run_len_reg;

        if (first_of_channel)
        begin
            // absolute value, pending run flushed ahead of it
            pair_en      = (run_len_reg != 8'd0);
            main_len     = burst_cnt_t'(2);
            run_len_next = '0;
        end
        else if (delta == 16'd0)
        begin
            // repeated sample: run grows, flushed when full or at channel end
            pair_cnt = run_inc;
            if (run_inc == RUN_LIMIT || last_of_channel)
            begin
                pair_en      = 1'b1;
                run_len_next = '0;
            end
            else
            begin
                run_len_next = run_inc;
            end
        end
        else
        begin
            // changed sample: flush run, then tagged delta
            pair_en      = (run_len_reg != 8'd0);
            main_len     = burst_cnt_t'(3);
            m0           = TAG_DELTA;
            m1           = delta[15:8];
            m2           = delta[7:0];
            run_len_next = '0;
        end

        if (pair_en)
        begin
            enc_bytes = '{TAG_RUN, pair_cnt, m0, m1, m2};
            enc_cnt   = main_len + burst_cnt_t'(2);
        end
        else
        begin
            enc_bytes = '{m0, m1, m2, TAG_RUN, TAG_RUN};
            enc_cnt   = main_len;
        end

        prev_sample_next = in_accept ? sample_value : prev_sample_reg;
        if (!in_accept)
        begin
            run_len_next = run_len_reg;
        end
    end

    // Stage movement
    always_comb
    begin
        a_valid_next = a_valid_reg;
        a_bytes_next = a_bytes_reg;
        a_cnt_next   = a_cnt_reg;
        b_valid_next = b_valid_reg;
        b_bytes_next = b_bytes_reg;
        b_cnt_next   = b_cnt_reg;
        b_idx_next   = b_idx_reg;

        if (in_accept && enc_cnt != '0)
        begin
            a_valid_next = 1'b1;
            a_bytes_next = enc_bytes;
            a_cnt_next   = enc_cnt;
        end
        else if (b_load)
        begin
            a_valid_next = 1'b0;
        end

        if (b_load)
        begin
            b_valid_next = 1'b1;
            b_bytes_next = a_bytes_reg;
            b_cnt_next   = a_cnt_reg;
            b_idx_next   = '0;
        end
        else if (b_done)
        begin
            b_valid_next = 1'b0;
        end
        else if (b_take)
        begin
            b_idx_next = b_idx_reg + burst_cnt_t'(1);
        end
    end

    // Control state and encoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= '0;
            run_len_reg     <= '0;
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            b_idx_reg       <= '0;
        end
        else
        begin
            prev_sample_reg <= prev_sample_next;
            run_len_reg     <= run_len_next;
            a_valid_reg     <= a_valid_next;
            b_valid_reg     <= b_valid_next;
            b_idx_reg       <= b_idx_next;
        end
    end

    // Byte payload, no reset
    always_ff @(posedge clk)
    begin
        a_bytes_reg <= a_bytes_next;
        a_cnt_reg   <= a_cnt_next;
        b_bytes_reg <= b_bytes_next;
        b_cnt_reg   <= b_cnt_next;
    end

endmodule

### src/drse_port_checker.sv
// drse_port_checker: port-level assertions for delta_rle_sample_encoder_unit.
// Depends on drse_pkg for the byte type; bound to the top level below.
module drse_port_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input drse_pkg::byte_t     out_byte,
    input logic                burst_end
);
    import drse_pkg::*;

    // A stalled output word holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(burst_end))
        else $error("stalled output word changed or dropped");

    // A burst does not end before its marked last byte is taken
    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !burst_end |=> out_valid)
        else $error("output burst ended early");

    // The input side only fills after it accepted a word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("input stall rose without an accepted word");

    // A new burst only starts from a held sample
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("output burst appeared without a held sample");

endmodule

bind delta_rle_sample_encoder_unit drse_port_checker u_drse_port_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .burst_end (burst_end)
);

### tb/sv/delta_rle_sample_encoder_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of delta_rle_sample_encoder_unit: directed table, long runs
// and random channels, every output byte checked against table or in-bench encoder.
// Depends on drse_pkg and the delta_rle_sample_encoder_unit RTL.
module delta_rle_sample_encoder_unit_test;

    import drse_pkg::*;

    typedef byte_t [0:BURST_MAX-1] burst_vec_t;

    // One expected output word: stream byte plus end-of-burst mark
    typedef struct packed {
        byte_t data;
        logic  tail;
    } coded_byte_t;

    // One row of the directed table; typed rows carry their bytes
    typedef struct packed {
        logic [15:0] smp;
        logic        f_mark;
        logic        l_mark;
        logic        typed;
        burst_cnt_t  n_bytes;
        burst_vec_t  bytes;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] sample_value = 16'h0000;
    logic        first_of_channel = 1'b0;
    logic        last_of_channel = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    byte_t       out_byte;
    logic        burst_end;

    // Encoder state mirror
    logic [15:0] prev_reading = 16'h0000;
    byte_t       repeat_count = 8'h00;

    coded_byte_t coded_q[$];
    stim_row_t   dir_rows[$];
    coded_byte_t got_word;
    int          err_cnt = 0;
    int          rand_items = 0;
    logic [15:0] gen_prev = 16'h0000;
    logic        wind_down = 1'b0;
    logic        tx_calm = 1'b0;

    delta_rle_sample_encoder_unit DUT
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample_value     (sample_value),
        .first_of_channel (first_of_channel),
        .last_of_channel  (last_of_channel),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_byte         (out_byte),
        .burst_end        (burst_end)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

    // Emit the pending run, if any, as TAG_RUN, count
    task automatic close_run(inout burst_vec_t bo, inout int n);
        if (repeat_count != 8'h00)
        begin
            bo[n] = TAG_RUN;
            bo[n + 1] = repeat_count;
            n = n + 2;
            repeat_count = 8'h00;
        end
    endtask

    // Encode one sample and update the mirrored state
    task automatic encode_sample(input logic [15:0] s, input logic f_mark, input logic l_mark,
                                 output burst_vec_t bo, output int n);
        logic [15:0] diff;
        n = 0;
        bo = '0;
        if (f_mark)
        begin
            close_run(bo, n);
            bo[n] = s[15:8];
            bo[n + 1] = s[7:0];
            n = n + 2;
        end
        else
        begin
            diff = s - prev_reading;
            if (diff == 16'h0000)
            begin
                repeat_count = repeat_count + 8'h01;
                if (repeat_count == RUN_LIMIT)
                    close_run(bo, n);
            end
            else
            begin
                close_run(bo, n);
                bo[n] = TAG_DELTA;
                bo[n + 1] = diff[15:8];
                bo[n + 2] = diff[7:0];
                n = n + 3;
            end
        end
        prev_reading = s;
        if (l_mark)
            close_run(bo, n);
    endtask

    // Drive one sample word, wait for acceptance, queue its bytes.
    // Entered at a rising edge; returns at the accepting edge.
    task automatic feed_sample(input logic [15:0] s, input logic f_mark, input logic l_mark,
                               input logic typed, input burst_cnt_t n_typed,
                               input burst_vec_t b_typed);
        burst_vec_t bo;
        int         n;
        sample_value     <= s;
        first_of_channel <= f_mark;
        last_of_channel  <= l_mark;
        in_valid         <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        encode_sample(s, f_mark, l_mark, bo, n);
        if (typed)
        begin
            bo = b_typed;
            n = int'(n_typed);
        end
        for (int i = 0; i < n; i++)
            coded_q.push_back({bo[i], i == n - 1});
        gen_prev = s;
    endtask

    // Random sender gap with in_valid low
    task automatic sender_pause();
        if (!wind_down && !tx_calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Hold the sender until every queued byte has come out
    task automatic drain();
        in_valid <= 1'b0;
        while (coded_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input logic [15:0] s, input logic f_mark, input logic l_mark,
                           input logic typed, input burst_cnt_t n, input burst_vec_t b);
        dir_rows.push_back({s, f_mark, l_mark, typed, n, b});
    endtask

    // One channel of random length; most are well formed, some have broken marks
    task automatic random_channel();
        int          len;
        int          mode;
        int          pick;
        logic [15:0] v;
        logic        f_mark;
        logic        l_mark;
        len = $urandom_range(1, 12);
        mode = $urandom_range(0, 99);
        tx_calm = ($urandom_range(0, 5) == 0);
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 9)
                v = gen_prev;
            else if (pick < 13)
                v = ($urandom_range(0, 1) == 1) ? gen_prev + 16'($urandom_range(1, 3))
                                                : gen_prev - 16'($urandom_range(1, 3));
            else if (pick < 16)
            begin
                case ($urandom_range(0, 3))
                    0: v = 16'h0000;
                    1: v = 16'hFFFF;
                    2: v = 16'h8000;
                    default: v = 16'h7FFF;
                endcase
            end
            else
                v = 16'($urandom);
            f_mark = (i == 0);
            l_mark = (i == len - 1);
            if (mode >= 80 && mode < 90)
                l_mark = 1'b0;
            else if (mode >= 90 && mode < 95)
                f_mark = (i != 0) && ($urandom_range(0, 7) == 0);
            else if (mode >= 95)
            begin
                f_mark = 1'($urandom_range(0, 1));
                l_mark = 1'($urandom_range(0, 1));
            end
            feed_sample(v, f_mark, l_mark, 1'b0, '0, '0);
            rand_items++;
            sender_pause();
        end
    endtask

    // Output checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (coded_q.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got byte %02h end %b",
                         $time, out_byte, burst_end);
                err_cnt++;
            end
            else
            begin
                got_word = coded_q.pop_front();
                if (out_byte !== got_word.data)
                begin
                    $display("%0t: out_byte expected %02h, got %02h",
                             $time, got_word.data, out_byte);
                    err_cnt++;
                end
                if (burst_end !== got_word.tail)
                begin
                    $display("%0t: burst_end expected %b, got %b",
                             $time, got_word.tail, burst_end);
                    err_cnt++;
                end
            end
        end
    end

    // Receiver stalls: random bursts, calm stretches, none while winding down
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!wind_down && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!wind_down && $urandom_range(0, 15) == 0)
                repeat ($urandom_range(20, 60)) @(posedge clk);
        end
    end

    // Stimulus
    initial
    begin
        logic [15:0] v;

        // Directed table: delta with no first mark after reset, runs, wrap, extremes,
        // missing end mark, one-sample channel, flushes on last
        add_row(16'h1234, 1'b0, 1'b0, 1'b1, 3'd3, {TAG_DELTA, 8'h12, 8'h34, 16'h0000});
        add_row(16'h1234, 1'b0, 1'b0, 1'b1, 3'd0, '0);
        add_row(16'h1234, 1'b0, 1'b0, 1'b1, 3'd0, '0);
        add_row(16'h1234, 1'b0, 1'b1, 1'b1, 3'd2, {TAG_RUN, 8'h03, 24'h000000});
        add_row(16'hFFFF, 1'b1, 1'b0, 1'b1, 3'd2, {8'hFF, 8'hFF, 24'h000000});
        add_row(16'h0000, 1'b0, 1'b0, 1'b1, 3'd3, {TAG_DELTA, 8'h00, 8'h01, 16'h0000});
        add_row(16'hFFFF, 1'b0, 1'b0, 1'b1, 3'd3, {TAG_DELTA, 8'hFF, 8'hFF, 16'h0000});
        add_row(16'hFFFF, 1'b0, 1'b0, 1'b1, 3'd0, '0);
        add_row(16'h8000, 1'b0, 1'b0, 1'b1, 3'd5, {TAG_RUN, 8'h01, TAG_DELTA, 8'h80, 8'h01});
        add_row(16'h8000, 1'b0, 1'b0, 1'b0, 3'd0, '0);
        add_row(16'h0000, 1'b1, 1'b0, 1'b1, 3'd4, {TAG_RUN, 8'h01, 8'h00, 8'h00, 8'h00});
        add_row(16'hABCD, 1'b1, 1'b1, 1'b1, 3'd2, {8'hAB, 8'hCD, 24'h000000});
        add_row(16'h5555, 1'b0, 1'b0, 1'b0, 3'd0, '0);
        add_row(16'h5555, 1'b0, 1'b1, 1'b1, 3'd2, {TAG_RUN, 8'h01, 24'h000000});
        add_row(16'h5555, 1'b0, 1'b1, 1'b1, 3'd2, {TAG_RUN, 8'h01, 24'h000000});
        add_row(16'h00FF, 1'b0, 1'b1, 1'b0, 3'd0, '0);
        add_row(16'h00FF, 1'b0, 1'b0, 1'b0, 3'd0, '0);
        add_row(16'h7F00, 1'b1, 1'b1, 1'b0, 3'd0, '0);
        add_row(16'h7FFF, 1'b0, 1'b0, 1'b0, 3'd0, '0);
        add_row(16'h0000, 1'b1, 1'b0, 1'b1, 3'd2, {8'h00, 8'h00, 24'h000000});
        add_row(16'h0000, 1'b0, 1'b1, 1'b1, 3'd2, {TAG_RUN, 8'h01, 24'h000000});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            feed_sample(dir_rows[i].smp, dir_rows[i].f_mark, dir_rows[i].l_mark,
                        dir_rows[i].typed, dir_rows[i].n_bytes, dir_rows[i].bytes);
            sender_pause();
        end
        drain();

        // Run reaching the limit mid-channel, then one more repeat on the last sample
        v = 16'($urandom);
        feed_sample(v, 1'b1, 1'b0, 1'b0, '0, '0);
        for (int k = 1; k <= 256; k++)
        begin
            feed_sample(v, 1'b0, k == 256, 1'b0, '0, '0);
            sender_pause();
        end
        drain();

        // Random channels; drains in a middle window, no idling near the end
        while (rand_items < 190)
        begin
            if (rand_items >= 165)
                wind_down = 1'b1;
            random_channel();
            if (rand_items >= 90 && rand_items < 102)
                drain();
        end

        drain();
        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
src/drse_pkg.sv
src/delta_rle_sample_encoder_unit.sv
src/drse_port_checker.sv
tb/sv/delta_rle_sample_encoder_unit_test.sv
